// ===== rtl/core/apg_pkg.sv =====
// package for the attractor point generator: widths, register codes, cordic constants
// used by apg_cordic and attractor_point_generator_top; no dependencies
package apg_pkg;

  localparam int COEF_W = 20;
  localparam int CTR_W = 11;
  localparam int PLOT_W = 13;
  localparam int COLOR_W = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int ATAN_ENTRIES = 28;
  // cordic datapath width: Q.30 values within a few units, plus guard
  localparam int CW = 34;
  // angle width: coef * pos shifted to Q.30 stays well within this
  localparam int AW = 48;

  localparam logic signed [AW-1:0] Q30_PI = AW'(64'sd3373259426);
  localparam logic signed [AW-1:0] Q30_HALF_PI = AW'(64'sd1686629713);
  localparam logic signed [AW-1:0] Q30_TWO_PI = AW'(64'sd6746518852);
  localparam logic signed [CW-1:0] Q30_GAIN = CW'(64'sd652032874);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_A = 3'd0,
    REG_COEF_B = 3'd1,
    REG_COEF_C = 3'd2,
    REG_COEF_D = 3'd3,
    REG_COEF_E = 3'd4,
    REG_COEF_F = 3'd5,
    REG_CENTRE_X = 3'd6,
    REG_CENTRE_Y = 3'd7
  } reg_idx_t;

  // truncated Q.30 arctangent table
  function automatic logic [CW-1:0] atan_q30(input logic [4:0] i);
    logic [CW-1:0] v;
    case (i)
      5'd0: v = CW'(32'h3243F6A8);
      5'd1: v = CW'(32'h1DAC6705);
      5'd2: v = CW'(32'h0FADBAFC);
      5'd3: v = CW'(32'h07F56EA6);
      5'd4: v = CW'(32'h03FEAB76);
      5'd5: v = CW'(32'h01FFD55B);
      5'd6: v = CW'(32'h00FFFAAA);
      5'd7: v = CW'(32'h007FFF55);
      5'd8: v = CW'(32'h003FFFEA);
      5'd9: v = CW'(32'h001FFFFD);
      5'd10: v = CW'(32'h000FFFFF);
      5'd11: v = CW'(32'h0007FFFF);
      5'd12: v = CW'(32'h0003FFFF);
      5'd13: v = CW'(32'h0001FFFF);
      5'd14: v = CW'(32'h0000FFFF);
      5'd15: v = CW'(32'h00007FFF);
      5'd16: v = CW'(32'h00003FFF);
      5'd17: v = CW'(32'h00001FFF);
      5'd18: v = CW'(32'h00000FFF);
      5'd19: v = CW'(32'h000007FF);
      5'd20: v = CW'(32'h000003FF);
      5'd21: v = CW'(32'h000001FF);
      5'd22: v = CW'(32'h000000FF);
      5'd23: v = CW'(32'h0000007F);
      5'd24: v = CW'(32'h0000003F);
      5'd25: v = CW'(32'h0000001F);
      5'd26: v = CW'(32'h0000000F);
      5'd27: v = CW'(32'h00000008);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/attractor_point_generator_top.sv =====
// top level of the attractor point generator: config registers, sequencer, output stage
// depends on apg_pkg and apg_cordic
//
// usage: one transaction on the slave stream (tdata[0] = restart) advances the
// 3-d attractor by one step and yields one transaction on the master stream
// carrying the screen point and colour. the config channel (cfg_valid/ready,
// cfg_index, cfg_data) writes coef_a..coef_f and centre_x/y; write only when idle.
// each step runs six sine/cosine evaluations on one shared cordic, each passing
// through multiply, start, reduction check, fold, rotations and done, with a
// further reduction check per 2*pi step of range reduction, then one scaling
// step. s_axis_tready is low while a step is in progress and while the result
// waits in the output register. if the receiver stalls, the result holds on
// m_axis_tdata and no new item is taken until it is delivered.
// reset clears the position to the origin, loads the default coefficients
// and centres, and empties the output register.
module attractor_point_generator_top #(
  parameter int FRAC_BITS = apg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [12:0] plot_x, [25:13] plot_y, [33:26] red,
                                      // [41:34] green, [49:42] blue
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import apg_pkg::*;

  localparam int PW = FRAC_BITS + 3;
  localparam int PRW = COEF_W + PW;

  typedef enum logic [2:0] {T_IDLE, T_MUL, T_START, T_WAIT, T_FINAL, T_OUT} state_t;

  state_t state;
  logic signed [COEF_W-1:0] coef [6];
  logic [CTR_W-1:0] centre_x, centre_y;
  logic signed [PW-1:0] pos_x, pos_y, pos_z;
  logic signed [PW-1:0] acc_x, acc_y, acc_z;
  logic [2:0] term;
  logic signed [PRW-1:0] prod;
  logic signed [AW-1:0] angle;
  logic cs_start, cs_done;
  logic signed [PW-1:0] cs_sin, cs_cos;

  logic signed [COEF_W-1:0] sel_coef;
  logic signed [PW-1:0] sel_pos;

  // operand selection per term: a*y, b*x, c*x, d*y, e*x, f*z
  always_comb begin
    sel_coef = coef[term];
    case (term)
      3'd0, 3'd3: sel_pos = pos_y;
      3'd5: sel_pos = pos_z;
      default: sel_pos = pos_x;
    endcase
  end

  // product scaled to Q.30 radians, presented to the cordic with the start pulse
  always_comb begin
    if (FRAC_BITS >= 14) angle = AW'(prod) >>> (FRAC_BITS - 14);
    else angle = AW'(prod) <<< (14 - FRAC_BITS);
  end

  apg_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .angle(angle),
    .done(cs_done), .sin_out(cs_sin), .cos_out(cs_cos)
  );

  // final scaling terms
  logic signed [PW+8:0] sx100, sy100;
  logic signed [PW+10:0] vx, vy;
  logic signed [PW+10:0] cr, cg, cb;
  logic signed [PW-1:0] pxs, pys;
  logic [COLOR_W-1:0] red_n, green_n, blue_n;
  logic signed [PLOT_W-1:0] plot_x_n, plot_y_n;

  function automatic logic [COLOR_W-1:0] sat8(input logic signed [PW+10:0] v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic signed [PLOT_W-1:0] satp(input logic signed [PW+10:0] v);
    if (v < -4096) return -13'sd4096;
    if (v > 4095) return 13'sd4095;
    return v[PLOT_W-1:0];
  endfunction

  always_comb begin
    sx100 = (PW+9)'(acc_x) * (PW+9)'(100);
    sy100 = (PW+9)'(acc_y) * (PW+9)'(100);
    vx = (PW+11)'(signed'({1'b0, centre_x}))
       + (PW+11)'((sx100 + (PW+9)'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
    vy = (PW+11)'(signed'({1'b0, centre_y}))
       - (PW+11)'((sy100 + (PW+9)'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
    cr = ((PW+11)'(306) <<< FRAC_BITS) + (PW+11)'(acc_z) * (PW+11)'(153)
       + ((PW+11)'(1) <<< FRAC_BITS);
    cg = ((PW+11)'(204) <<< FRAC_BITS) - (PW+11)'(acc_z) * (PW+11)'(102)
       + ((PW+11)'(1) <<< FRAC_BITS);
    cb = ((PW+11)'(459) <<< FRAC_BITS) - (PW+11)'(acc_z) * (PW+11)'(204)
       + ((PW+11)'(1) <<< FRAC_BITS);
    red_n = sat8(cr >>> (FRAC_BITS+1));
    green_n = sat8(cg >>> (FRAC_BITS+1));
    blue_n = sat8(cb >>> (FRAC_BITS+1));
    plot_x_n = satp(vx);
    plot_y_n = satp(vy);
    pxs = acc_x;
    pys = acc_y;
  end

  assign s_axis_tready = (state == T_IDLE);
  assign cfg_ready = 1'b1;
  assign cs_start = (state == T_START);
  assign m_axis_tvalid = (state == T_OUT);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= 20'sd116736;
      coef[1] <= -20'sd51200;
      coef[2] <= 20'sd124928;
      coef[3] <= 20'sd174080;
      coef[4] <= 20'sd45875;
      coef[5] <= -20'sd72090;
      centre_x <= 11'd320;
      centre_y <= 11'd240;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COEF_A: coef[0] <= cfg_data;
        REG_COEF_B: coef[1] <= cfg_data;
        REG_COEF_C: coef[2] <= cfg_data;
        REG_COEF_D: coef[3] <= cfg_data;
        REG_COEF_E: coef[4] <= cfg_data;
        REG_COEF_F: coef[5] <= cfg_data;
        REG_CENTRE_X: centre_x <= cfg_data[CTR_W-1:0];
        REG_CENTRE_Y: centre_y <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // step sequencer: six terms through multiplier and cordic, then output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      term <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tdata[0]) begin
              pos_x <= '0;
              pos_y <= '0;
              pos_z <= '0;
            end
            term <= '0;
            acc_x <= '0;
            acc_y <= '0;
            acc_z <= '0;
            state <= T_MUL;
          end
        end
        T_MUL: begin
          prod <= PRW'(sel_coef) * PRW'(sel_pos);
          state <= T_START;
        end
        T_START: begin
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (cs_done) begin
            case (term)
              3'd0: acc_x <= acc_x + cs_sin;
              3'd1: acc_x <= acc_x - cs_cos;
              3'd2: acc_y <= acc_y + cs_sin;
              3'd3: acc_y <= acc_y - cs_cos;
              3'd4: acc_z <= acc_z + cs_sin;
              default: acc_z <= acc_z - cs_cos;
            endcase
            term <= term + 3'd1;
            state <= (term == 3'd5) ? T_FINAL : T_MUL;
          end
        end
        T_FINAL: begin
          pos_x <= pxs;
          pos_y <= pys;
          pos_z <= acc_z;
          m_axis_tdata <= {6'd0, blue_n, green_n, red_n, plot_y_n, plot_x_n};
          state <= T_OUT;
        end
        T_OUT: begin
          if (m_axis_tready) state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/apg_cordic.sv =====
// iterative rotation-mode cordic: sine and cosine of a Q.30 angle, one micro-rotation a cycle
// depends on apg_pkg
module apg_cordic #(
  parameter int FRAC_BITS = apg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [apg_pkg::AW-1:0]     angle,
  output logic                              done,
  output logic signed [FRAC_BITS+2:0]       sin_out,
  output logic signed [FRAC_BITS+2:0]       cos_out
);
  import apg_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int SH = 30 - FRAC_BITS;

  typedef enum logic [1:0] {S_IDLE, S_RED1, S_RED2, S_ROT} state_t;

  state_t state;
  logic signed [AW-1:0] r;
  logic signed [CW-1:0] cx, cy;
  logic neg;
  logic [4:0] step;

  logic signed [CW-1:0] sx, sy, fx, fy;
  logic signed [AW-1:0] at;
  logic signed [AW-1:0] r_fold;

  always_comb begin
    sx = cx >>> step;
    sy = cy >>> step;
    at = AW'(signed'({1'b0, atan_q30(step)}));
    fx = neg ? -cx : cx;
    fy = neg ? -cy : cy;
    r_fold = (r > Q30_PI) ? r - Q30_TWO_PI : r;
  end

  // sequencer: range reduction by repeated 2*pi steps, fold, then rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            r <= angle;
            state <= S_RED1;
          end
        end
        S_RED1: begin
          done <= 1'b0;
          // bring into [0, 2*pi); angles stay within a few turns
          if (r < 0) r <= r + Q30_TWO_PI;
          else if (r >= Q30_TWO_PI) r <= r - Q30_TWO_PI;
          else state <= S_RED2;
        end
        S_RED2: begin
          done <= 1'b0;
          cx <= Q30_GAIN;
          cy <= '0;
          step <= '0;
          neg <= (r_fold > Q30_HALF_PI) || (r_fold < -Q30_HALF_PI);
          if (r_fold > Q30_HALF_PI) begin
            r <= r_fold - Q30_PI;
          end else if (r_fold < -Q30_HALF_PI) begin
            r <= r_fold + Q30_PI;
          end else begin
            r <= r_fold;
          end
          state <= S_ROT;
        end
        S_ROT: begin
          if (r >= 0) begin
            cx <= cx - sy;
            cy <= cy + sx;
            r <= r - at;
          end else begin
            cx <= cx + sy;
            cy <= cy - sx;
            r <= r + at;
          end
          step <= step + 5'd1;
          if (step == 5'(NSTEP - 1)) state <= S_IDLE;
          done <= (step == 5'(NSTEP - 1));
        end
        default: begin
          done <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // results hold after done until the next start
  always_comb begin
    sin_out = (FRAC_BITS+3)'(fy >>> SH);
    cos_out = (FRAC_BITS+3)'(fx >>> SH);
  end

endmodule

// ===== rtl/core/apg_checker.sv =====
// port-level checker for the attractor point generator, bound to the top level
// depends only on the top level's ports
module apg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // no new item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");
  // an accepted item is followed by a busy block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not busy after accept");
  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:50] == 6'd0)
    else $error("padding not zero");
endmodule

bind attractor_point_generator_top apg_checker u_apg_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
